/* rtl/core/text_mode_terminal_writer_defines.svh */
// assertion helpers for the terminal writer checker
`ifndef TEXT_MODE_TERMINAL_WRITER_DEFINES_SVH
`define TEXT_MODE_TERMINAL_WRITER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TMTW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("terminal writer check failed");

// next-cycle implication, clocked on clk, off during reset
`define TMTW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("terminal writer check failed");

`endif

/* rtl/core/tmtw_pkg.sv */
`timescale 1ns / 1ps
package tmtw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);

  // fixed field widths
  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int CELL_ADR_W = 11;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int CELL_W     = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd2;

  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic [CHAR_W-1:0]     char_code;
    logic [CELL_ADR_W-1:0] cell_address;
  } request_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } result_t;

endpackage

/* rtl/core/tmtw_cell_mem.sv */
`timescale 1ns / 1ps
module tmtw_cell_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tmtw_pkg::ADDR_W-1:0] waddr,
  input  logic [tmtw_pkg::CELL_W-1:0] wdata,
  input  logic                       re,
  input  logic [tmtw_pkg::ADDR_W-1:0] raddr,
  output logic [tmtw_pkg::CELL_W-1:0] rdata
);
  import tmtw_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // one registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/text_mode_terminal_writer.sv */
`timescale 1ns / 1ps
// Text screen writer: a start with busy low takes one command word, and exactly one result
// word comes back on result with done high for a single cycle; the receiver cannot hold it off.
// A put without scroll answers in the next cycle, a read of a cell from state S_READ after the
// registered memory read, an unused code or out-of-range read in the next cycle. A put that
// scrolls holds busy high and answers in the cycle after its last fill write: CELLS - COLUMNS
// copies, then the last copy write, then COLUMNS blank fills, one cell per cycle through the
// single write port of the cell memory. A clear holds busy high while it fills every cell the
// same way and answers in the cycle after its last fill. After reset the screen memory is
// filled with blanks with busy high; colour writes are taken at any time.
module text_mode_terminal_writer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  tmtw_pkg::request_t             request,
  output logic                           done,
  output tmtw_pkg::result_t              result,
  input  logic                           cfg_we,
  input  logic [tmtw_pkg::COLOR_W-1:0]   cfg_data
);
  import tmtw_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;

  localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] FIRST_FILL = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);

  logic [2:0]         state;
  logic [COLOR_W-1:0] text_color;
  logic [COLOR_W-1:0] fill_color;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   column;
  logic [ADDR_W-1:0]  ptr;
  logic               copy_valid;
  logic [ADDR_W-1:0]  copy_addr;
  logic               report;
  logic               scroll_flag;

  logic               accept;
  logic               addr_ok;
  logic [ADDR_W-1:0]  cur_idx;
  logic [ROW_W:0]     row_inc;
  logic [COL_W:0]     col_inc;
  logic [ROW_W:0]     row_next;
  logic [COL_W-1:0]   col_next;
  logic               need_scroll;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [CELL_W-1:0]  mem_rdata;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign addr_ok = ({1'b0, request.cell_address} < (CELL_ADR_W + 1)'(CELLS));
  assign cur_idx = ADDR_W'({{(ADDR_W - ROW_W){1'b0}}, row} * ROW_STRIDE)
                 + ADDR_W'(column);

  // cursor step for a put
  always_comb begin
    row_inc  = {1'b0, row} + 1'b1;
    col_inc  = {1'b0, column} + 1'b1;
    row_next = {1'b0, row};
    col_next = column;
    if (request.char_code == NEWLINE_CODE) begin
      row_next = row_inc;
      col_next = '0;
    end else if (col_inc == (COL_W + 1)'(COLUMNS)) begin
      row_next = row_inc;
      col_next = '0;
    end else begin
      col_next = col_inc[COL_W-1:0];
    end
    need_scroll = (row_next == (ROW_W + 1)'(ROWS));
  end

  // memory port steering: copy writes first, then fills, then a put
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = {fill_color, SPACE_CODE};
    priority if (copy_valid) begin
      mem_we    = 1'b1;
      mem_waddr = copy_addr;
      mem_wdata = mem_rdata;
    end else if (state == S_FILL) begin
      mem_we = 1'b1;
    end else if (accept && request.command == CMD_PUT
                 && request.char_code != NEWLINE_CODE) begin
      mem_we    = 1'b1;
      mem_waddr = cur_idx;
      mem_wdata = {text_color, request.char_code};
    end else begin
      mem_we = 1'b0;
    end
    mem_re    = 1'b0;
    mem_raddr = ptr + ROW_STRIDE;
    priority if (state == S_SCROLL) begin
      mem_re = 1'b1;
    end else if (accept && request.command == CMD_READ && addr_ok) begin
      mem_re    = 1'b1;
      mem_raddr = ADDR_W'(request.cell_address);
    end else begin
      mem_re = 1'b0;
    end
  end

  tmtw_cell_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // colour register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (cfg_we) begin
      text_color <= cfg_data;
    end
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_FILL;
      ptr         <= '0;
      fill_color  <= RESET_COLOR;
      report      <= 1'b0;
      scroll_flag <= 1'b0;
      copy_valid  <= 1'b0;
      copy_addr   <= '0;
      row         <= '0;
      column      <= '0;
      done        <= 1'b0;
      result      <= '0;
    end else begin
      done       <= 1'b0;
      copy_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (request.command)
              CMD_PUT: begin
                if (need_scroll) begin
                  row         <= ROW_W'(ROWS - 1);
                  column      <= col_next;
                  state       <= S_SCROLL;
                  ptr         <= '0;
                  fill_color  <= text_color;
                  report      <= 1'b1;
                  scroll_flag <= 1'b1;
                end else begin
                  row    <= row_next[ROW_W-1:0];
                  column <= col_next;
                  done   <= 1'b1;
                  result <= '{row_next[ROW_W-1:0], col_next, '0, 1'b0};
                end
              end
              CMD_CLEAR: begin
                row         <= '0;
                column      <= '0;
                state       <= S_FILL;
                ptr         <= '0;
                fill_color  <= text_color;
                report      <= 1'b1;
                scroll_flag <= 1'b0;
              end
              CMD_READ: begin
                if (addr_ok) begin
                  state <= S_READ;
                end else begin
                  done   <= 1'b1;
                  result <= '{row, column, '0, 1'b0};
                end
              end
              default: begin
                done   <= 1'b1;
                result <= '{row, column, '0, 1'b0};
              end
            endcase
          end
        end
        S_READ: begin
          done   <= 1'b1;
          result <= '{row, column, mem_rdata, 1'b0};
          state  <= S_IDLE;
        end
        S_SCROLL: begin
          // read a row below, write it one row up in the next cycle
          copy_valid <= 1'b1;
          copy_addr  <= ptr;
          if (ptr == LAST_COPY) begin
            ptr   <= FIRST_FILL;
            state <= S_FILL;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_FILL: begin
          // the last copy write holds the port before the fills begin
          if (!copy_valid) begin
            if (ptr == LAST_CELL) begin
              state <= S_IDLE;
              if (report) begin
                done   <= 1'b1;
                result <= '{row, column, '0, scroll_flag};
              end
            end else begin
              ptr <= ptr + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/tmtw_checker.sv */
`timescale 1ns / 1ps
`include "text_mode_terminal_writer_defines.svh"
module tmtw_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input tmtw_pkg::request_t request,
  input logic               done,
  input tmtw_pkg::result_t  result
);
  import tmtw_pkg::*;

  logic cursor_on_screen;

  assign cursor_on_screen = (result.cursor_row < ROW_W'(ROWS))
                         && (result.cursor_column < COL_W'(COLUMNS));

  // cursor reported on the screen
  `TMTW_ASSERT_SAME(a_cursor_range, done, cursor_on_screen)
  // a scroll leaves the cursor on the last row
  `TMTW_ASSERT_SAME(a_scroll_row, done && result.scrolled, result.cursor_row == ROW_W'(ROWS - 1))
  // a clear word keeps the block busy while it fills
  `TMTW_ASSERT_NEXT(a_clear_busy, start && !busy && request.command == CMD_CLEAR, busy && !done)
  // a put word answers at once or starts a scroll
  `TMTW_ASSERT_NEXT(a_put_answer, start && !busy && request.command == CMD_PUT, done || busy)

endmodule

bind text_mode_terminal_writer tmtw_checker u_tmtw_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);

/* bench/text_mode_terminal_writer_test.sv */
`timescale 1ns / 1ps
module text_mode_terminal_writer_test;
  import tmtw_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int PHASE_ITEMS   = 15;
  localparam int PHASES        = 4;
  localparam int SETTLE_CYCLES = CELLS + 100;
  localparam int MAX_REPORTS   = 10;

  typedef enum logic {STEP_ITEM, STEP_COLOR} step_kind_t;

  // one row of the directed table
  typedef struct {
    step_kind_t         kind;
    request_t           req;
    logic [COLOR_W-1:0] color;
    bit                 pinned;
    result_t            want;
  } step_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  request_t           request;
  logic               done;
  result_t            result;
  logic               cfg_we;
  logic [COLOR_W-1:0] cfg_data;

  // expectation typed into the table, travels with the word it belongs to
  bit      pin_valid;
  result_t pin_result;

  // screen model
  logic [CELL_W-1:0]  screen [CELLS];
  int unsigned        cur_row;
  int unsigned        cur_col;
  logic [COLOR_W-1:0] pen_color;

  result_t pending_results[$];
  bit      idle_on;
  int      cycle_count;
  int      failures;
  int      words_taken;
  int      results_checked;
  int      scroll_count;
  int      clear_count;
  int      color_writes;

  text_mode_terminal_writer DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // apply one command word to the screen model, return the result word it gives
  function automatic result_t terminal_apply(request_t r);
    result_t     o;
    int unsigned pos;
    int          i;
    o = '0;
    case (r.command)
      CMD_PUT: begin
        if (r.char_code == NEWLINE_CODE) begin
          cur_row++;
          cur_col = 0;
        end else begin
          pos = cur_row * COLUMNS + cur_col;
          if (pos < CELLS) screen[pos] = {pen_color, r.char_code};
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // past the last row: shift everything up one row, blank the bottom one
        if (cur_row >= ROWS) begin
          for (i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
          for (i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {pen_color, SPACE_CODE};
          cur_row    = ROWS - 1;
          o.scrolled = 1'b1;
        end
      end
      CMD_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen[i] = {pen_color, SPACE_CODE};
        cur_row = 0;
        cur_col = 0;
      end
      CMD_READ: begin
        if (r.cell_address < CELLS) o.cell_value = screen[r.cell_address];
      end
      default: ;
    endcase
    o.cursor_row    = cur_row[ROW_W-1:0];
    o.cursor_column = cur_col[COL_W-1:0];
    return o;
  endfunction

  function automatic request_t make_req(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                        logic [CELL_ADR_W-1:0] adr);
    request_t r;
    r.command      = cmd;
    r.char_code    = ch;
    r.cell_address = adr;
    return r;
  endfunction

  function automatic step_t item(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                 logic [CELL_ADR_W-1:0] adr);
    step_t s;
    s.kind   = STEP_ITEM;
    s.req    = make_req(cmd, ch, adr);
    s.color  = '0;
    s.pinned = 1'b0;
    s.want   = '0;
    return s;
  endfunction

  function automatic step_t pinned_item(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                        logic [CELL_ADR_W-1:0] adr, int row, int col,
                                        logic [CELL_W-1:0] value);
    step_t s;
    s        = item(cmd, ch, adr);
    s.pinned = 1'b1;
    s.want.cursor_row    = row[ROW_W-1:0];
    s.want.cursor_column = col[COL_W-1:0];
    s.want.cell_value    = value;
    s.want.scrolled      = 1'b0;
    return s;
  endfunction

  function automatic step_t recolor(logic [COLOR_W-1:0] c);
    step_t s;
    s       = item(CMD_PUT, '0, '0);
    s.kind  = STEP_COLOR;
    s.color = c;
    return s;
  endfunction

  // result check, then color writes, then words taken at this edge
  always @(posedge clk) begin : screen_monitor
    result_t want;
    result_t predicted;
    int      i;
    cycle_count++;
    if (rst) begin
      for (i = 0; i < CELLS; i++) screen[i] = {RESET_COLOR, SPACE_CODE};
      cur_row   = 0;
      cur_col   = 0;
      pen_color = RESET_COLOR;
    end else begin
      if (done === 1'b1) begin
        if (pending_results.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("unexpected result word: row %0d col %0d cell %h scroll %b",
                     result.cursor_row, result.cursor_column, result.cell_value,
                     result.scrolled);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (result.scrolled === 1'b1) scroll_count++;
          if (result.cursor_row !== want.cursor_row ||
              result.cursor_column !== want.cursor_column ||
              result.cell_value !== want.cell_value ||
              result.scrolled !== want.scrolled) begin
            failures++;
            if (failures <= MAX_REPORTS)
              $display("mismatch: expected row %0d col %0d cell %h scroll %b, ",
                       want.cursor_row, want.cursor_column, want.cell_value,
                       want.scrolled,
                       "got row %0d col %0d cell %h scroll %b",
                       result.cursor_row, result.cursor_column, result.cell_value,
                       result.scrolled);
          end
        end
      end
      if (cfg_we === 1'b1) pen_color = cfg_data;
      if (start === 1'b1 && busy === 1'b0) begin
        words_taken++;
        if (request.command == CMD_CLEAR) clear_count++;
        predicted = terminal_apply(request);
        pending_results.push_back(pin_valid ? pin_result : predicted);
      end
    end
  end

  // hand over one command word, maybe after a random idle burst
  task automatic send(request_t r, bit pin, result_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start      <= 1'b1;
    request    <= r;
    pin_valid  <= pin;
    pin_result <= want;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // wait until the last word taken has answered and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // color register is only written with nothing in flight
  task automatic set_color(logic [COLOR_W-1:0] c);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    color_writes++;
  endtask

  task automatic send_put(logic [CHAR_W-1:0] ch);
    send(make_req(CMD_PUT, ch, CELL_ADR_W'($urandom_range(0, 2047))), 1'b0, '0);
  endtask

  initial begin : stimulus
    step_t              steps[$];
    int                 phase;
    int                 count;
    int                 sel;
    int                 n;
    int                 base;
    int                 pick;
    bit                 calm_end;
    logic [COLOR_W-1:0] phase_color;

    start      = 1'b0;
    request    = '0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    pin_valid  = 1'b0;
    pin_result = '0;
    idle_on    = 1'b0;

    // directed table: reset contents, field extremes, unused code, clear, color change
    steps.push_back(pinned_item(CMD_READ, 8'h00, 11'd0, 0, 0, 16'h0220));
    steps.push_back(pinned_item(CMD_READ, 8'hFF, 11'd1999, 0, 0, 16'h0220));
    steps.push_back(pinned_item(CMD_READ, 8'h00, 11'd2000, 0, 0, 16'h0000));
    steps.push_back(pinned_item(CMD_READ, 8'h00, 11'd2047, 0, 0, 16'h0000));
    steps.push_back(pinned_item(CMD_UNUSED, 8'hFF, 11'd2047, 0, 0, 16'h0000));
    steps.push_back(pinned_item(CMD_PUT, 8'h00, 11'd0, 0, 1, 16'h0000));
    steps.push_back(pinned_item(CMD_PUT, 8'hFF, 11'd2047, 0, 2, 16'h0000));
    steps.push_back(pinned_item(CMD_READ, 8'h00, 11'd0, 0, 2, 16'h0200));
    steps.push_back(pinned_item(CMD_READ, 8'h00, 11'd1, 0, 2, 16'h02FF));
    steps.push_back(pinned_item(CMD_PUT, NEWLINE_CODE, 11'd2047, 1, 0, 16'h0000));
    steps.push_back(recolor(8'hFF));
    steps.push_back(pinned_item(CMD_PUT, 8'h41, 11'd0, 1, 1, 16'h0000));
    steps.push_back(pinned_item(CMD_READ, 8'h00, 11'd80, 1, 1, 16'hFF41));
    steps.push_back(pinned_item(CMD_READ, 8'h00, 11'd1, 1, 1, 16'h02FF));
    steps.push_back(item(CMD_PUT, 8'h55, 11'h555));
    steps.push_back(item(CMD_PUT, 8'hAA, 11'h2AA));
    steps.push_back(item(CMD_READ, 8'h00, 11'h555));
    steps.push_back(item(CMD_READ, 8'h00, 11'h2AA));
    steps.push_back(pinned_item(CMD_CLEAR, 8'hFF, 11'd2047, 0, 0, 16'h0000));
    steps.push_back(pinned_item(CMD_READ, 8'h00, 11'd1, 0, 0, 16'hFF20));
    steps.push_back(pinned_item(CMD_READ, 8'h00, 11'd1999, 0, 0, 16'hFF20));
    steps.push_back(recolor(8'h00));
    steps.push_back(item(CMD_PUT, 8'h20, 11'd0));
    steps.push_back(item(CMD_UNUSED, NEWLINE_CODE, 11'd0));
    steps.push_back(pinned_item(CMD_READ, 8'h00, 11'd0, 0, 1, 16'h0020));

    while (rst !== 1'b0) @(posedge clk);
    idle_on = 1'b1;
    foreach (steps[k]) begin
      if (steps[k].kind == STEP_COLOR) set_color(steps[k].color);
      else send(steps[k].req, steps[k].pinned, steps[k].want);
    end

    // random phases, one color setting each, no idling in the last one
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       phase_color = 8'hFF;
        2:       phase_color = 8'h00;
        default: phase_color = COLOR_W'($urandom_range(0, 255));
      endcase
      set_color(phase_color);
      calm_end = (phase == PHASES - 1);
      count = 0;
      while (count < PHASE_ITEMS) begin
        idle_on = !calm_end && ($urandom_range(0, 2) != 0);
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
          // run of newlines, sometimes long enough to reach the bottom row and scroll
          n = $urandom_range(1, 30);
          repeat (n) send_put(NEWLINE_CODE);
        end else if (sel < 55) begin
          n = $urandom_range(1, 6);
          repeat (n) send_put(CHAR_W'($urandom_range(0, 255)));
        end else if (sel < 65) begin
          // text up to and just past the end of the row, wraps the cursor
          n = COLUMNS - int'(cur_col) + $urandom_range(0, 2);
          repeat (n) send_put(CHAR_W'($urandom_range(11, 255)));
        end else if (sel < 88) begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
              base = int'(cur_row * COLUMNS + cur_col) - $urandom_range(1, 8);
              if (base < 0) base = 0;
            end else if (pick < 9) begin
              base = $urandom_range(0, CELLS - 1);
            end else begin
              base = $urandom_range(CELLS, 2047);
            end
            send(make_req(CMD_READ, CHAR_W'($urandom_range(0, 255)), CELL_ADR_W'(base)),
                 1'b0, '0);
          end
        end else if (sel < 94) begin
          n = 1;
          send(make_req(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                        CELL_ADR_W'($urandom_range(0, 2047))), 1'b0, '0);
        end else begin
          n = 1;
          send(make_req(CMD_UNUSED, CHAR_W'($urandom_range(0, 255)),
                        CELL_ADR_W'($urandom_range(0, 2047))), 1'b0, '0);
        end
        count += n;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d command words taken, %0d results checked, %0d failures",
             words_taken, results_checked, failures);
    $display("%0d scrolls, %0d clears, %0d color settings", scroll_count, clear_count,
             color_writes);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
